/* src/camera_ray_direction_macros.svh */
// ----------------------------------------------------------------------------
// camera_ray_direction assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CAMERA_RAY_DIRECTION_MACROS_SVH
`define CAMERA_RAY_DIRECTION_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRD_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/crd_pkg.sv */
// ----------------------------------------------------------------------------
// crd_pkg
// Widths, register codes and shared types of the camera ray direction block.
// ----------------------------------------------------------------------------
package crd_pkg;

    localparam int COORD_BITS  = 12;
    localparam int FRAC_BITS   = 14;
    localparam int SCALE_FRAC  = 22;
    localparam int NORM_BITS   = 30;
    localparam int RECIP_SHIFT = 62;

    localparam int VEC_W   = 48;
    localparam int COMP_W  = 16;
    localparam int SCALE_W = 24;
    localparam int HALF_W  = 12;
    localparam int DATA_W  = 64;
    localparam int ADDR_W  = 6;

    localparam int DX_W   = ((COORD_BITS > HALF_W) ? COORD_BITS : HALF_W) + 1;
    localparam int SX_W   = DX_W + SCALE_W + 1;
    localparam int PROD_W = SX_W + COMP_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int LB_W   = $clog2(SUM_W + 1);

    localparam int SQ_W     = 2 * NORM_BITS;
    localparam int SUMSQ_W  = SQ_W + 2;
    localparam int SQ_STEPS = (SUMSQ_W + 2) / 2;
    localparam int SQ_ACC_W = 2 * SQ_STEPS;
    localparam int LEN_W    = NORM_BITS + 1;
    localparam int RCP_W    = RECIP_SHIFT - NORM_BITS + 2;
    localparam int MUL_W    = NORM_BITS + RCP_W;
    localparam int RND_SH   = RECIP_SHIFT - FRAC_BITS;
    localparam int Q_W      = MUL_W + 1 - RND_SH;

    typedef enum logic [2:0] {
        REG_FORWARD = 3'd0,
        REG_RIGHT   = 3'd1,
        REG_UP      = 3'd2,
        REG_HSCALE  = 3'd3,
        REG_VSCALE  = 3'd4,
        REG_HWIDTH  = 3'd5,
        REG_HHEIGHT = 3'd6
    } reg_idx_t;

    // Normalized magnitudes, signs and the zero flag that ride along the
    // square root and reciprocal pipelines.
    typedef struct packed {
        logic [2:0][NORM_BITS-1:0] mag;
        logic [2:0]                neg;
        logic                      degen;
    } side_t;

endpackage

/* src/crd_isqrt.sv */
// ----------------------------------------------------------------------------
// crd_isqrt
// Pipelined bitwise integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module crd_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [crd_pkg::SUMSQ_W-1:0]   in_sumsq,
    input  crd_pkg::side_t                in_side,
    output logic                          out_valid,
    output logic [crd_pkg::LEN_W-1:0]     out_len,
    output crd_pkg::side_t                out_side
);
    import crd_pkg::*;

    logic                vld_reg  [1:SQ_STEPS];
    logic [SQ_ACC_W-1:0] rem_reg  [1:SQ_STEPS];
    logic [SQ_ACC_W-1:0] res_reg  [1:SQ_STEPS];
    side_t               side_reg [1:SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
        localparam logic [SQ_ACC_W-1:0] BIT_K =
            SQ_ACC_W'(1) << (SQ_ACC_W - 2 - 2 * k);

        logic                v_cur;
        logic [SQ_ACC_W-1:0] rem_cur;
        logic [SQ_ACC_W-1:0] res_cur;
        side_t               side_cur;
        logic [SQ_ACC_W-1:0] trial;
        logic [SQ_ACC_W-1:0] rem_next;
        logic [SQ_ACC_W-1:0] res_next;

        if (k == 0) begin : g_first
            assign v_cur    = in_valid;
            assign rem_cur  = SQ_ACC_W'(in_sumsq);
            assign res_cur  = '0;
            assign side_cur = in_side;
        end
        else begin : g_rest
            assign v_cur    = vld_reg[k];
            assign rem_cur  = rem_reg[k];
            assign res_cur  = res_reg[k];
            assign side_cur = side_reg[k];
        end

        always_comb
        begin
            trial = res_cur + BIT_K;
            if (rem_cur >= trial)
            begin
                rem_next = rem_cur - trial;
                res_next = (res_cur >> 1) + BIT_K;
            end
            else
            begin
                rem_next = rem_cur;
                res_next = res_cur >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= v_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= rem_next;
                res_reg[k+1]  <= res_next;
                side_reg[k+1] <= side_cur;
            end
        end
    end

    assign out_valid = vld_reg[SQ_STEPS];
    assign out_len   = res_reg[SQ_STEPS][LEN_W-1:0];
    assign out_side  = side_reg[SQ_STEPS];

endmodule

/* src/crd_recip.sv */
// ----------------------------------------------------------------------------
// crd_recip
// Pipelined restoring division of a power of two by the vector length.
// ----------------------------------------------------------------------------
module crd_recip (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [crd_pkg::LEN_W-1:0] in_len,
    input  crd_pkg::side_t            in_side,
    output logic                      out_valid,
    output logic [crd_pkg::RCP_W-1:0] out_recip,
    output crd_pkg::side_t            out_side
);
    import crd_pkg::*;

    // The dividend bits above the quotient width form the starting remainder;
    // all lower dividend bits are zero.
    localparam logic [LEN_W-1:0] REM_INIT = LEN_W'(1) << (RECIP_SHIFT - RCP_W);

    logic             vld_reg  [1:RCP_W];
    logic [LEN_W-1:0] rem_reg  [1:RCP_W];
    logic [LEN_W-1:0] len_reg  [1:RCP_W];
    logic [RCP_W-1:0] quo_reg  [1:RCP_W];
    side_t            side_reg [1:RCP_W];

    for (genvar k = 0; k < RCP_W; k++) begin : g_step
        logic             v_cur;
        logic [LEN_W-1:0] rem_cur;
        logic [LEN_W-1:0] len_cur;
        logic [RCP_W-1:0] quo_cur;
        side_t            side_cur;
        logic [LEN_W:0]   shifted;
        logic [LEN_W:0]   diff;
        logic             take;
        logic [LEN_W-1:0] rem_next;
        logic [RCP_W-1:0] quo_next;

        if (k == 0) begin : g_first
            assign v_cur    = in_valid;
            assign rem_cur  = REM_INIT;
            assign len_cur  = in_len;
            assign quo_cur  = '0;
            assign side_cur = in_side;
        end
        else begin : g_rest
            assign v_cur    = vld_reg[k];
            assign rem_cur  = rem_reg[k];
            assign len_cur  = len_reg[k];
            assign quo_cur  = quo_reg[k];
            assign side_cur = side_reg[k];
        end

        always_comb
        begin
            shifted  = {rem_cur, 1'b0};
            diff     = shifted - {1'b0, len_cur};
            take     = (shifted >= {1'b0, len_cur});
            rem_next = take ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];
            quo_next = {quo_cur[RCP_W-2:0], take};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= v_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= rem_next;
                len_reg[k+1]  <= len_cur;
                quo_reg[k+1]  <= quo_next;
                side_reg[k+1] <= side_cur;
            end
        end
    end

    assign out_valid = vld_reg[RCP_W];
    assign out_recip = quo_reg[RCP_W];
    assign out_side  = side_reg[RCP_W];

endmodule

/* src/camera_ray_direction.sv */
// Camera ray direction: turns a pixel coordinate into the unit direction of
// the primary ray through it, forward + sx*right + sy*up normalized.
// The pixel channel (pix_valid, pix_stall, pixel_x, pixel_y) takes one word
// in every cycle in which pix_valid is high and pix_stall is low. The result
// channel (dir_valid, dir_stall, dir_x, dir_y, dir_z, degenerate) gives one
// word per pixel, in order.
// Eight arithmetic stages, 32 square root stages, 34 reciprocal stages, a
// multiply stage and the output register lie between acceptance and
// dir_valid. Unless dir_stall freezes them, throughput is one word per cycle,
// set by the fully pipelined root and divider with one bit step per stage.
// When dir_stall holds a waiting result, the whole pipeline freezes and
// pix_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads forward = +x, everything else zero.
// The user must write registers over the APB port only while the pipeline
// is empty; the block does not enforce it. Register i sits at byte address 8*i.
`include "camera_ray_direction_macros.svh"

// ----------------------------------------------------------------------------
// camera_ray_direction
// Pinhole camera primary rays in a deep pipeline, one per clock unless stalled.
// ----------------------------------------------------------------------------
module camera_ray_direction (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [crd_pkg::ADDR_W-1:0]     paddr,
    input  logic [crd_pkg::DATA_W-1:0]     pwdata,
    output logic [crd_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    input  logic                           pix_valid,
    output logic                           pix_stall,
    input  logic [crd_pkg::COORD_BITS-1:0] pixel_x,
    input  logic [crd_pkg::COORD_BITS-1:0] pixel_y,
    output logic                           dir_valid,
    input  logic                           dir_stall,
    output logic signed [15:0]             dir_x,
    output logic signed [15:0]             dir_y,
    output logic signed [15:0]             dir_z,
    output logic                           degenerate
);
    import crd_pkg::*;

    // ---------------- configuration registers ----------------
    logic [VEC_W-1:0]   fwd_reg, right_reg, up_reg;
    logic [SCALE_W-1:0] hs_reg, vs_reg;
    logic [HALF_W-1:0]  hw_reg, hh_reg;
    reg_idx_t           reg_idx;
    logic               wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg   <= VEC_W'(16384);
            right_reg <= '0;
            up_reg    <= '0;
            hs_reg    <= '0;
            vs_reg    <= '0;
            hw_reg    <= '0;
            hh_reg    <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_FORWARD: fwd_reg   <= pwdata[VEC_W-1:0];
                REG_RIGHT:   right_reg <= pwdata[VEC_W-1:0];
                REG_UP:      up_reg    <= pwdata[VEC_W-1:0];
                REG_HSCALE:  hs_reg    <= pwdata[SCALE_W-1:0];
                REG_VSCALE:  vs_reg    <= pwdata[SCALE_W-1:0];
                REG_HWIDTH:  hw_reg    <= pwdata[HALF_W-1:0];
                REG_HHEIGHT: hh_reg    <= pwdata[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_FORWARD: prdata = DATA_W'(fwd_reg);
            REG_RIGHT:   prdata = DATA_W'(right_reg);
            REG_UP:      prdata = DATA_W'(up_reg);
            REG_HSCALE:  prdata = DATA_W'(hs_reg);
            REG_VSCALE:  prdata = DATA_W'(vs_reg);
            REG_HWIDTH:  prdata = DATA_W'(hw_reg);
            REG_HHEIGHT: prdata = DATA_W'(hh_reg);
            default:     prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    logic adv;
    logic out_v_reg;

    assign adv       = !(out_v_reg && dir_stall);
    assign pix_stall = !adv;

    // ---------------- stage 1: offsets times scales ----------------
    logic signed [DX_W-1:0] dx_next, dy_next;
    logic signed [SX_W-1:0] dxe, dye, hse, vse;
    logic signed [SX_W-1:0] sx_next, sy_next;
    logic signed [SX_W-1:0] sx_reg, sy_reg;
    logic                   v1_reg;

    always_comb
    begin
        dx_next = $signed(DX_W'(pixel_x)) - $signed(DX_W'(hw_reg));
        dy_next = $signed(DX_W'(pixel_y)) - $signed(DX_W'(hh_reg));
        dxe     = SX_W'(dx_next);
        dye     = SX_W'(dy_next);
        hse     = $signed(SX_W'(hs_reg));
        vse     = $signed(SX_W'(vs_reg));
        sx_next = dxe * hse;
        sy_next = dye * vse;
    end

    // ---------------- stage 2: scaled basis products ----------------
    logic signed [COMP_W-1:0] rc [3];
    logic signed [COMP_W-1:0] uc [3];
    logic signed [COMP_W-1:0] fc [3];
    logic signed [PROD_W-1:0] pr_next [3];
    logic signed [PROD_W-1:0] pu_next [3];
    logic signed [PROD_W-1:0] pr_reg  [3];
    logic signed [PROD_W-1:0] pu_reg  [3];
    logic                     v2_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rc[i]      = $signed(right_reg[COMP_W*i +: COMP_W]);
            uc[i]      = $signed(up_reg[COMP_W*i +: COMP_W]);
            fc[i]      = $signed(fwd_reg[COMP_W*i +: COMP_W]);
            pr_next[i] = PROD_W'(sx_reg) * PROD_W'(rc[i]);
            pu_next[i] = PROD_W'(sy_reg) * PROD_W'(uc[i]);
        end
    end

    // ---------------- stage 3: component sums ----------------
    logic signed [SUM_W-1:0] sum_next [3];
    logic signed [SUM_W-1:0] sum_reg  [3];
    logic                    v3_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum_next[i] = (SUM_W'(fc[i]) <<< SCALE_FRAC)
                        + SUM_W'(pr_reg[i]) + SUM_W'(pu_reg[i]);
        end
    end

    // ---------------- stage 4: sign and magnitude ----------------
    logic [SUM_W-1:0] mag_next [3];
    logic [SUM_W-1:0] mag_reg  [3];
    logic [2:0]       neg_next, neg_reg, neg5_reg;
    logic [SUM_W-1:0] orv_next, orv_reg;
    logic             v4_reg;

    always_comb
    begin
        orv_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            neg_next[i] = sum_reg[i][SUM_W-1];
            mag_next[i] = neg_next[i] ? (~sum_reg[i] + 1'b1) : sum_reg[i];
            orv_next    = orv_next | mag_next[i];
        end
    end

    // ---------------- stage 5: bit length of the largest magnitude ----------
    // The OR of the magnitudes has the same bit length as their maximum.
    logic [LB_W-1:0]  blen_next, blen_reg;
    logic             zero_next, zero_reg;
    logic [SUM_W-1:0] mag5_reg [3];
    logic             v5_reg;

    always_comb
    begin
        blen_next = '0;
        for (int i = 0; i < SUM_W; i++)
        begin
            if (orv_reg[i])
            begin
                blen_next = LB_W'(i + 1);
            end
        end
        zero_next = (orv_reg == '0);
    end

    // ---------------- stage 6: block normalization ----------------
    side_t           side6_next, side6_reg;
    logic [LB_W-1:0] sh_amt;
    logic            v6_reg;

    always_comb
    begin
        if (blen_reg > LB_W'(NORM_BITS))
        begin
            sh_amt = blen_reg - LB_W'(NORM_BITS);
        end
        else
        begin
            sh_amt = LB_W'(NORM_BITS) - blen_reg;
        end
        for (int i = 0; i < 3; i++)
        begin
            if (blen_reg > LB_W'(NORM_BITS))
            begin
                side6_next.mag[i] = NORM_BITS'(mag5_reg[i] >> sh_amt);
            end
            else
            begin
                side6_next.mag[i] = NORM_BITS'(mag5_reg[i] << sh_amt);
            end
        end
        side6_next.neg   = neg5_reg;
        side6_next.degen = zero_reg;
    end

    // ---------------- stage 7: squares ----------------
    logic [SQ_W-1:0] sq_next [3];
    logic [SQ_W-1:0] sq_reg  [3];
    side_t           side7_reg;
    logic            v7_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_next[i] = SQ_W'(side6_reg.mag[i]) * SQ_W'(side6_reg.mag[i]);
        end
    end

    // ---------------- stage 8: sum of squares ----------------
    logic [SUMSQ_W-1:0] sumsq_next, sumsq_reg;
    side_t              side8_reg;
    logic               v8_reg;

    assign sumsq_next = SUMSQ_W'(sq_reg[0]) + SUMSQ_W'(sq_reg[1])
                      + SUMSQ_W'(sq_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= pix_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            pr_reg    <= pr_next;
            pu_reg    <= pu_next;
            sum_reg   <= sum_next;
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
            orv_reg   <= orv_next;
            mag5_reg  <= mag_reg;
            neg5_reg  <= neg_reg;
            blen_reg  <= blen_next;
            zero_reg  <= zero_next;
            side6_reg <= side6_next;
            sq_reg    <= sq_next;
            side7_reg <= side6_reg;
            sumsq_reg <= sumsq_next;
            side8_reg <= side7_reg;
        end
    end

    // ---------------- length and reciprocal ----------------
    logic             sq_v;
    logic [LEN_W-1:0] len;
    side_t            sq_side;
    logic             rc_v;
    logic [RCP_W-1:0] recip;
    side_t            rc_side;

    crd_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v8_reg),
        .in_sumsq  (sumsq_reg),
        .in_side   (side8_reg),
        .out_valid (sq_v),
        .out_len   (len),
        .out_side  (sq_side)
    );

    crd_recip u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (sq_v),
        .in_len    (len),
        .in_side   (sq_side),
        .out_valid (rc_v),
        .out_recip (recip),
        .out_side  (rc_side)
    );

    // ---------------- scaling by the reciprocal ----------------
    logic [MUL_W-1:0] prod_next [3];
    logic [MUL_W-1:0] prod_reg  [3];
    side_t            sidep_reg;
    logic             vp_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i] = MUL_W'(rc_side.mag[i]) * MUL_W'(recip);
        end
    end

    // ---------------- rounding, sign and saturation ----------------
    logic [MUL_W:0]     rnd [3];
    logic [Q_W-1:0]     q [3];
    logic [Q_W-1:0]     negq [3];
    logic signed [15:0] dir_next [3];
    logic signed [15:0] dir_reg  [3];
    logic               degen_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rnd[i]  = {1'b0, prod_reg[i]} + ((MUL_W + 1)'(1) << (RND_SH - 1));
            q[i]    = rnd[i][MUL_W:RND_SH];
            negq[i] = Q_W'(0) - q[i];
            if (sidep_reg.degen)
            begin
                dir_next[i] = '0;
            end
            else if (sidep_reg.neg[i])
            begin
                dir_next[i] = (q[i] > Q_W'(32768)) ? 16'sh8000 : $signed(negq[i][15:0]);
            end
            else
            begin
                dir_next[i] = (q[i] > Q_W'(32767)) ? 16'sh7FFF : $signed(q[i][15:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            vp_reg    <= rc_v;
            out_v_reg <= vp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg  <= prod_next;
            sidep_reg <= rc_side;
            dir_reg   <= dir_next;
            degen_reg <= sidep_reg.degen;
        end
    end

    assign dir_valid  = out_v_reg;
    assign dir_x      = dir_reg[0];
    assign dir_y      = dir_reg[1];
    assign dir_z      = dir_reg[2];
    assign degenerate = degen_reg;

    // ---------------- assertions ----------------
    `CRD_ASSERT_IMPLY(a_degen_zero, out_v_reg && degen_reg,
        (dir_reg[0] == 16'sd0) && (dir_reg[1] == 16'sd0) && (dir_reg[2] == 16'sd0),
        "degenerate word carries a nonzero direction")
    `CRD_ASSERT_IMPLY(a_unit_nonzero, out_v_reg && !degen_reg,
        (dir_reg[0] != 16'sd0) || (dir_reg[1] != 16'sd0) || (dir_reg[2] != 16'sd0),
        "normalized direction came out all zero")
    `CRD_ASSERT_NEXT(a_pixel_enters, pix_valid && !pix_stall, v1_reg,
        "accepted pixel did not enter the first stage")

endmodule
